// File: rtl/core/suspension_spring_damper_force_macros.svh
// Assertion macros shared by the spring and damper force block
`ifndef SUSPENSION_SPRING_DAMPER_FORCE_MACROS_SVH
`define SUSPENSION_SPRING_DAMPER_FORCE_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define SSDF_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check a condition in the cycle after its trigger
`define SSDF_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: rtl/core/ssdf_pkg.sv
// Shared widths, limits, register indexes and types of the spring and damper force block
package ssdf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int LEN_W     = 32;
  localparam int DT_W      = 31;
  localparam int RATE_W    = 40;
  localparam int KNEE_W    = 31;
  localparam int QUO_W     = 32;
  localparam int FORCE_W   = 48;
  localparam int CLAMP_W   = 41;
  localparam int CFG_IDX_W = 3;

  // Multiplier split: 40-bit rate times 32-bit operand as two partial products
  localparam int MUL_B_W   = 32;
  localparam int MUL_SPLIT = 24;
  localparam int PROD_W    = RATE_W + MUL_B_W;
  localparam int ACC_W     = PROD_W + 1;

  localparam longint FORCE_LIMIT_INT = 10000000;

  localparam logic signed [LEN_W-1:0]   LEN_MAX   = {1'b0, {(LEN_W-1){1'b1}}};
  localparam logic signed [LEN_W-1:0]   LEN_MIN   = {1'b1, {(LEN_W-1){1'b0}}};
  localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_LENGTH,
    CFG_SPRING_RATE,
    CFG_BUMP_SLOW_RATE,
    CFG_BUMP_FAST_RATE,
    CFG_BUMP_KNEE,
    CFG_REBOUND_SLOW_RATE,
    CFG_REBOUND_FAST_RATE,
    CFG_REBOUND_KNEE
  } cfg_idx_t;

  // Sideband carried alongside the velocity divider
  typedef struct packed {
    logic signed [LEN_W-1:0] comp;
    logic                    neg;
    logic                    zero;
  } div_side_t;

endpackage

// File: rtl/core/ssdf_divider.sv
// Pipelined restoring divider: (magnitude << FRAC_BITS) / time step, one quotient bit per stage
module ssdf_divider
  import ssdf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [LEN_W:0]    in_mag,
  input  logic [DT_W-1:0]   in_dt,
  input  div_side_t         in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output logic              out_ovf,
  output div_side_t         out_side
);

  localparam int DVD_W = LEN_W + 1 + FRAC_BITS;
  localparam int HI_W  = DVD_W - QUO_W;
  localparam int CMP_W = (HI_W > DT_W) ? HI_W : DT_W;
  localparam int STEPS = QUO_W;

  logic [DVD_W-1:0] dvd;
  logic [CMP_W-1:0] hi_ext;
  logic [CMP_W-1:0] dt_ext;

  logic [STEPS:0]    vld_r;
  logic [DT_W-1:0]   rem_r  [STEPS+1];
  logic [QUO_W-1:0]  lo_r   [STEPS+1];
  logic [QUO_W-1:0]  quo_r  [STEPS+1];
  logic [DT_W-1:0]   dt_r   [STEPS+1];
  logic [STEPS:0]    ovf_r;
  div_side_t         side_r [STEPS+1];

  assign dvd    = {in_mag, {FRAC_BITS{1'b0}}};
  assign hi_ext = CMP_W'(dvd[DVD_W-1:QUO_W]);
  assign dt_ext = CMP_W'(in_dt);

  // Advance valid bits with the transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STEPS-1:0], in_valid};
    end
  end

  // Set up: flag a quotient too large for 32 bits, seed the remainder with the top part
  always_ff @(posedge clk) begin
    rem_r[0]  <= hi_ext[DT_W-1:0];
    lo_r[0]   <= dvd[QUO_W-1:0];
    quo_r[0]  <= '0;
    dt_r[0]   <= in_dt;
    ovf_r[0]  <= (hi_ext >= dt_ext);
    side_r[0] <= in_side;
  end

  // One trial subtraction per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [DT_W:0]   trial;
    logic [DT_W+1:0] sub;
    logic            ge;

    assign trial = {rem_r[k], lo_r[k][QUO_W-1]};
    assign sub   = {1'b0, trial} - {2'b0, dt_r[k]};
    assign ge    = !sub[DT_W+1];

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? sub[DT_W-1:0] : trial[DT_W-1:0];
      lo_r[k+1]   <= lo_r[k] << 1;
      quo_r[k+1]  <= {quo_r[k][QUO_W-2:0], ge};
      dt_r[k+1]   <= dt_r[k];
      ovf_r[k+1]  <= ovf_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_quo   = quo_r[STEPS];
  assign out_ovf   = ovf_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

// File: rtl/core/ssdf_mul.sv
// Two-stage 40 x 32 unsigned multiplier built from two narrower partial products
module ssdf_mul
  import ssdf_pkg::*;
(
  input  logic               clk,
  input  logic [RATE_W-1:0]  in_a,
  input  logic [MUL_B_W-1:0] in_b,
  output logic [PROD_W-1:0]  out_prod
);

  localparam int HI_W = RATE_W - MUL_SPLIT;

  logic [MUL_SPLIT+MUL_B_W-1:0] plo_r;
  logic [HI_W+MUL_B_W-1:0]      phi_r;
  logic [PROD_W-1:0]            prod_r;

  // Form partial products, then combine them
  always_ff @(posedge clk) begin
    plo_r  <= in_a[MUL_SPLIT-1:0] * in_b;
    phi_r  <= in_a[RATE_W-1:MUL_SPLIT] * in_b;
    prod_r <= {phi_r, {MUL_SPLIT{1'b0}}} + PROD_W'(plo_r);
  end

  assign out_prod = prod_r;

endmodule

// File: rtl/core/ssdf_scale.sv
// Drop the fraction bits of a product magnitude, apply its sign and saturate to 48 bits
module ssdf_scale
  import ssdf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic [ACC_W-1:0]          in_mag,
  input  logic                      in_neg,
  output logic signed [FORCE_W-1:0] out_force
);

  localparam int SH_W = ACC_W - FRAC_BITS;

  logic [SH_W-1:0]           sh;
  logic                      over_pos;
  logic                      over_neg;
  logic [FORCE_W-1:0]        m;
  logic signed [FORCE_W-1:0] fval_nxt;
  logic signed [FORCE_W-1:0] fval_r;

  assign sh       = in_mag[ACC_W-1:FRAC_BITS];
  assign over_pos = |sh[SH_W-1:FORCE_W-1];
  assign over_neg = (|sh[SH_W-1:FORCE_W]) || (sh[FORCE_W-1] && (|sh[FORCE_W-2:0]));

  // Limit the magnitude, the negative side reaches one step further
  always_comb begin
    if (in_neg) begin
      m        = over_neg ? $unsigned(FORCE_MIN) : sh[FORCE_W-1:0];
      fval_nxt = -$signed(m);
    end else begin
      m        = over_pos ? $unsigned(FORCE_MAX) : sh[FORCE_W-1:0];
      fval_nxt = $signed(m);
    end
  end

  always_ff @(posedge clk) begin
    fval_r <= fval_nxt;
  end

  assign out_force = fval_r;

endmodule

// File: rtl/core/suspension_spring_damper_force.sv
// Top level of the suspension spring and damper force block
//
// Computes, for one wheel sample, compression against the configured zero
// length, velocity as length change over time step, spring force, bilinear
// bump/rebound damping, their saturated total and the total clamped to 1e7.
// All values are fixed point with FRAC_BITS fraction bits.
//
// Input: a transaction is taken at a clock edge with start high and busy low.
// busy is high during reset and in the cycle after it; otherwise a sample can enter
// every cycle, so throughput is one transaction per clock.
// Output: out_valid strobes for one cycle with all result fields; a result
// passes the velocity divider, whose 32 stages give one quotient bit each,
// and the registered stages of subtract, multiply and saturate.
// The receiver cannot hold results off, so nothing ever stalls.
// Configuration: write cfg_wdata to register cfg_index while cfg_wr_en is
// high; write only while no transaction is in flight.
// Reset (synchronous, active low) clears the configuration and valid
// registers, and so every in-flight transaction.
`include "suspension_spring_damper_force_macros.svh"

module suspension_spring_damper_force
  import ssdf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [LEN_W-1:0]   in_prev_length,
  input  logic signed [LEN_W-1:0]   in_spring_length,
  input  logic [DT_W-1:0]           in_time_step,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [RATE_W-1:0]         cfg_wdata,
  output logic                      out_valid,
  output logic signed [LEN_W-1:0]   out_compression,
  output logic signed [LEN_W-1:0]   out_velocity,
  output logic signed [FORCE_W-1:0] out_spring_force,
  output logic signed [FORCE_W-1:0] out_damping_force,
  output logic signed [FORCE_W-1:0] out_total_force,
  output logic signed [CLAMP_W-1:0] out_clamped_force,
  output logic                      out_was_clamped
);

  localparam int DIV_LAT  = QUO_W + 1;
  localparam int POST_N   = 9;
  localparam int PIPE_LAT = 2 + DIV_LAT + POST_N;

  localparam logic signed [63:0] FORCE_LIM     = 64'(FORCE_LIMIT_INT) <<< FRAC_BITS;
  localparam logic signed [63:0] FORCE_NEG_LIM = -FORCE_LIM;

  typedef struct packed {
    logic signed [LEN_W-1:0] comp;
    logic signed [LEN_W-1:0] vel;
  } kin_t;

  typedef struct packed {
    logic reb;
    logic cneg;
  } sgn_t;

  // Configuration registers
  logic signed [LEN_W-1:0] zero_length_r;
  logic [RATE_W-1:0]       spring_rate_r;
  logic [RATE_W-1:0]       bump_slow_rate_r;
  logic [RATE_W-1:0]       bump_fast_rate_r;
  logic [KNEE_W-1:0]       bump_knee_r;
  logic [RATE_W-1:0]       rebound_slow_rate_r;
  logic [RATE_W-1:0]       rebound_fast_rate_r;
  logic [KNEE_W-1:0]       rebound_knee_r;

  logic busy_r;
  logic fire;

  // Stage 1 and 2
  logic signed [LEN_W:0]   diff_nxt;
  logic signed [LEN_W:0]   comp_full;
  logic signed [LEN_W-1:0] comp_nxt;
  logic                    s1_vld_r;
  logic signed [LEN_W:0]   s1_diff_r;
  logic signed [LEN_W-1:0] s1_comp_r;
  logic [DT_W-1:0]         s1_dt_r;
  logic                    s2_vld_r;
  logic [LEN_W:0]          s2_dmag_r;
  div_side_t               s2_side_r;
  logic [DT_W-1:0]         s2_dt_r;

  // Divider outputs
  logic                    d_vld;
  logic [QUO_W-1:0]        d_quo;
  logic                    d_ovf;
  div_side_t               d_side;

  // Post-divider stages
  logic [POST_N-1:0]       vld_r;
  logic signed [LEN_W-1:0] vel_nxt;
  kin_t                    pv_kin_r;
  kin_t                    pa_kin_r;
  logic [LEN_W-1:0]        pa_vabs_r;
  logic [LEN_W-1:0]        pa_cmag_r;
  sgn_t                    pa_sgn_r;
  logic [RATE_W-1:0]       sel_slow;
  logic [RATE_W-1:0]       sel_fast;
  logic [LEN_W-1:0]        sel_knee;
  logic                    knee_le;
  logic [LEN_W-1:0]        over_knee;
  kin_t                    pb_kin_r;
  sgn_t                    pb_sgn_r;
  logic [RATE_W-1:0]       pb_slow_r;
  logic [RATE_W-1:0]       pb_fast_r;
  logic [LEN_W-1:0]        pb_a_r;
  logic [LEN_W-1:0]        pb_b_r;
  logic [LEN_W-1:0]        pb_cmag_r;
  kin_t                    pm1_kin_r;
  sgn_t                    pm1_sgn_r;
  kin_t                    pm2_kin_r;
  sgn_t                    pm2_sgn_r;
  logic [PROD_W-1:0]       p_spring;
  logic [PROD_W-1:0]       p_slow;
  logic [PROD_W-1:0]       p_fast;
  kin_t                    ps_kin_r;
  logic                    ps_reb_r;
  logic [ACC_W-1:0]        ps_dm_r;
  logic signed [FORCE_W-1:0] spring_s;
  logic signed [FORCE_W-1:0] damp_d;
  kin_t                    pd_kin_r;
  logic signed [FORCE_W-1:0] pd_spring_r;
  logic signed [FORCE_W:0]   total_sum;
  logic signed [FORCE_W-1:0] total_nxt;
  kin_t                    pt_kin_r;
  logic signed [FORCE_W-1:0] pt_spring_r;
  logic signed [FORCE_W-1:0] pt_damp_r;
  logic signed [FORCE_W-1:0] pt_total_r;
  logic signed [63:0]        total_ext;
  logic signed [FORCE_W-1:0] clamp_nxt;
  logic                      clamped_nxt;

  // Hold configuration, write on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_length_r       <= '0;
      spring_rate_r       <= '0;
      bump_slow_rate_r    <= '0;
      bump_fast_rate_r    <= '0;
      bump_knee_r         <= '0;
      rebound_slow_rate_r <= '0;
      rebound_fast_rate_r <= '0;
      rebound_knee_r      <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ZERO_LENGTH:       zero_length_r       <= cfg_wdata[LEN_W-1:0];
        CFG_SPRING_RATE:       spring_rate_r       <= cfg_wdata;
        CFG_BUMP_SLOW_RATE:    bump_slow_rate_r    <= cfg_wdata;
        CFG_BUMP_FAST_RATE:    bump_fast_rate_r    <= cfg_wdata;
        CFG_BUMP_KNEE:         bump_knee_r         <= cfg_wdata[KNEE_W-1:0];
        CFG_REBOUND_SLOW_RATE: rebound_slow_rate_r <= cfg_wdata;
        CFG_REBOUND_FAST_RATE: rebound_fast_rate_r <= cfg_wdata;
        CFG_REBOUND_KNEE:      rebound_knee_r      <= cfg_wdata[KNEE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold off the input for the cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign fire = start && !busy_r;

  // Stage 1: length change and saturated compression
  assign diff_nxt  = (LEN_W+1)'(in_spring_length) - (LEN_W+1)'(in_prev_length);
  assign comp_full = (LEN_W+1)'(zero_length_r) - (LEN_W+1)'(in_spring_length);

  always_comb begin
    if (comp_full[LEN_W] != comp_full[LEN_W-1]) begin
      comp_nxt = comp_full[LEN_W] ? LEN_MIN : LEN_MAX;
    end else begin
      comp_nxt = comp_full[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_diff_r <= diff_nxt;
    s1_comp_r <= comp_nxt;
    s1_dt_r   <= in_time_step;
  end

  // Stage 2: magnitude and sign of the length change
  always_ff @(posedge clk) begin
    s2_dmag_r      <= s1_diff_r[LEN_W] ? (LEN_W+1)'(-s1_diff_r) : (LEN_W+1)'(s1_diff_r);
    s2_side_r.comp <= s1_comp_r;
    s2_side_r.neg  <= s1_diff_r[LEN_W];
    s2_side_r.zero <= (s1_diff_r == '0);
    s2_dt_r        <= s1_dt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= fire;
      s2_vld_r <= s1_vld_r;
    end
  end

  ssdf_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_vld_r),
    .in_mag    (s2_dmag_r),
    .in_dt     (s2_dt_r),
    .in_side   (s2_side_r),
    .out_valid (d_vld),
    .out_quo   (d_quo),
    .out_ovf   (d_ovf),
    .out_side  (d_side)
  );

  // Advance valid bits through the force stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[POST_N-2:0], d_vld};
    end
  end

  // Velocity: signed, saturated quotient; a zero step or a huge quotient saturates
  always_comb begin
    if (d_side.zero) begin
      vel_nxt = '0;
    end else if (d_ovf || d_quo[QUO_W-1]) begin
      vel_nxt = d_side.neg ? LEN_MIN : LEN_MAX;
    end else if (d_side.neg) begin
      vel_nxt = -$signed(d_quo);
    end else begin
      vel_nxt = $signed(d_quo);
    end
  end

  always_ff @(posedge clk) begin
    pv_kin_r.comp <= d_side.comp;
    pv_kin_r.vel  <= vel_nxt;
  end

  // Magnitudes and signs of velocity and compression
  always_ff @(posedge clk) begin
    pa_kin_r      <= pv_kin_r;
    pa_vabs_r     <= pv_kin_r.vel[LEN_W-1] ? LEN_W'(-pv_kin_r.vel) : LEN_W'(pv_kin_r.vel);
    pa_cmag_r     <= pv_kin_r.comp[LEN_W-1] ? LEN_W'(-pv_kin_r.comp) : LEN_W'(pv_kin_r.comp);
    pa_sgn_r.reb  <= !pv_kin_r.vel[LEN_W-1] && (pv_kin_r.vel != '0);
    pa_sgn_r.cneg <= pv_kin_r.comp[LEN_W-1];
  end

  // Pick bump or rebound coefficients and split speed at the knee
  assign sel_slow  = pa_sgn_r.reb ? rebound_slow_rate_r : bump_slow_rate_r;
  assign sel_fast  = pa_sgn_r.reb ? rebound_fast_rate_r : bump_fast_rate_r;
  assign sel_knee  = LEN_W'(pa_sgn_r.reb ? rebound_knee_r : bump_knee_r);
  assign knee_le   = (pa_vabs_r <= sel_knee);
  assign over_knee = pa_vabs_r - sel_knee;

  always_ff @(posedge clk) begin
    pb_kin_r  <= pa_kin_r;
    pb_sgn_r  <= pa_sgn_r;
    pb_slow_r <= sel_slow;
    pb_fast_r <= sel_fast;
    pb_a_r    <= knee_le ? pa_vabs_r : sel_knee;
    pb_b_r    <= knee_le ? '0 : over_knee;
    pb_cmag_r <= pa_cmag_r;
  end

  ssdf_mul u_mul_spring (
    .clk      (clk),
    .in_a     (spring_rate_r),
    .in_b     (pb_cmag_r),
    .out_prod (p_spring)
  );

  ssdf_mul u_mul_slow (
    .clk      (clk),
    .in_a     (pb_slow_r),
    .in_b     (pb_a_r),
    .out_prod (p_slow)
  );

  ssdf_mul u_mul_fast (
    .clk      (clk),
    .in_a     (pb_fast_r),
    .in_b     (pb_b_r),
    .out_prod (p_fast)
  );

  // Carry sideband alongside the multipliers
  always_ff @(posedge clk) begin
    pm1_kin_r <= pb_kin_r;
    pm1_sgn_r <= pb_sgn_r;
    pm2_kin_r <= pm1_kin_r;
    pm2_sgn_r <= pm1_sgn_r;
  end

  // Sum the slow and fast damping parts exactly
  always_ff @(posedge clk) begin
    ps_kin_r <= pm2_kin_r;
    ps_reb_r <= pm2_sgn_r.reb;
    ps_dm_r  <= ACC_W'(p_slow) + ACC_W'(p_fast);
  end

  ssdf_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale_spring (
    .clk       (clk),
    .in_mag    (ACC_W'(p_spring)),
    .in_neg    (pm2_sgn_r.cneg),
    .out_force (spring_s)
  );

  // Damping opposes velocity: negative on rebound
  ssdf_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale_damp (
    .clk       (clk),
    .in_mag    (ps_dm_r),
    .in_neg    (ps_reb_r),
    .out_force (damp_d)
  );

  always_ff @(posedge clk) begin
    pd_kin_r    <= ps_kin_r;
    pd_spring_r <= spring_s;
  end

  // Saturated total
  assign total_sum = (FORCE_W+1)'(pd_spring_r) + (FORCE_W+1)'(damp_d);

  always_comb begin
    if (total_sum[FORCE_W] != total_sum[FORCE_W-1]) begin
      total_nxt = total_sum[FORCE_W] ? FORCE_MIN : FORCE_MAX;
    end else begin
      total_nxt = total_sum[FORCE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    pt_kin_r    <= pd_kin_r;
    pt_spring_r <= pd_spring_r;
    pt_damp_r   <= damp_d;
    pt_total_r  <= total_nxt;
  end

  // Clamp the total to the force limit
  assign total_ext = 64'(pt_total_r);

  always_comb begin
    if (total_ext > FORCE_LIM) begin
      clamp_nxt   = FORCE_LIM[FORCE_W-1:0];
      clamped_nxt = 1'b1;
    end else if (total_ext < FORCE_NEG_LIM) begin
      clamp_nxt   = FORCE_NEG_LIM[FORCE_W-1:0];
      clamped_nxt = 1'b1;
    end else begin
      clamp_nxt   = pt_total_r;
      clamped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_compression   <= pt_kin_r.comp;
    out_velocity      <= pt_kin_r.vel;
    out_spring_force  <= pt_spring_r;
    out_damping_force <= pt_damp_r;
    out_total_force   <= pt_total_r;
    out_clamped_force <= clamp_nxt[CLAMP_W-1:0];
    out_was_clamped   <= clamped_nxt;
  end

  assign out_valid = vld_r[POST_N-1];

  // Every result strobe belongs to an accepted transaction
  `SSDF_ASSERT_NOW(a_latency, out_valid, $past(start && !busy, PIPE_LAT), "result without matching transaction")

  // An unclamped result passes the total through unchanged
  `SSDF_ASSERT_NOW(a_clamp_pass, out_valid && !out_was_clamped, out_total_force[CLAMP_W-1:0] == $unsigned(out_clamped_force), "clamped force differs from unclamped total")

  // Rebound never produces a positive damping force
  `SSDF_ASSERT_NOW(a_damp_sign, out_valid && (out_velocity > 0), out_damping_force[FORCE_W-1] || (out_damping_force == '0), "damping does not oppose rebound")

  // A non-zero velocity keeps the sign of the length change
  `SSDF_ASSERT_NEXT(a_vel_sign, d_vld && !d_side.zero && (d_ovf || (d_quo != '0)), pv_kin_r.vel[LEN_W-1] == $past(d_side.neg), "velocity sign lost")

endmodule
